@@ hw/rtl/cdq_pkg.sv @@
// cdq_pkg: shared types and constants for the circular deque
// payload structs, operation codes and register widths; no dependencies
package cdq_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int CAP_W     = 5;
  localparam int DEPTH_DEF = 16;
  localparam int CAP_RESET = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
  } deque_in_t;

  typedef struct packed {
    logic                     error;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CAP_W-1:0]         occupancy;
  } deque_out_t;

  // per-step status handed from the controller to the result stage
  typedef struct packed {
    logic             error;
    logic             is_empty;
    logic             is_full;
    logic [CAP_W-1:0] occupancy;
  } step_status_t;

endpackage

@@ hw/rtl/cdq_ram.sv @@
// cdq_ram: entry store, one write port and two registered read ports
// same-cycle write/read collisions are forwarded; uses cdq_pkg
module cdq_ram #(
  parameter int Depth = cdq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [$clog2(Depth)-1:0]    waddr_i,
  input  logic [cdq_pkg::WORD_W-1:0]  wdata_i,
  input  logic [$clog2(Depth)-1:0]    raddr_f_i,
  input  logic [$clog2(Depth)-1:0]    raddr_r_i,
  output logic [cdq_pkg::WORD_W-1:0]  rdata_f_o,
  output logic [cdq_pkg::WORD_W-1:0]  rdata_r_o
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] mem [Depth];
  logic [WORD_W-1:0] rd_f_q, rd_r_q, wdata_q;
  logic              fwd_f_q, fwd_r_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_f_q  <= mem[raddr_f_i];
    rd_r_q  <= mem[raddr_r_i];
    wdata_q <= wdata_i;
  end

  // read returns old contents, so a read of the entry being written takes the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_f_q <= 1'b0;
      fwd_r_q <= 1'b0;
    end else begin
      fwd_f_q <= we_i && (waddr_i == raddr_f_i);
      fwd_r_q <= we_i && (waddr_i == raddr_r_i);
    end
  end

  assign rdata_f_o = fwd_f_q ? wdata_q : rd_f_q;
  assign rdata_r_o = fwd_r_q ? wdata_q : rd_r_q;

endmodule

@@ hw/rtl/cdq_ctrl.sv @@
// cdq_ctrl: capacity register, ring pointers and count; drives the store
// issues the write and both reads for each step; uses cdq_pkg
module cdq_ctrl #(
  parameter int Depth = cdq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  cdq_pkg::deque_in_t          item_i,
  input  logic                        cfg_we_i,
  input  logic [cdq_pkg::CAP_W-1:0]   cfg_data_i,
  output logic                        we_o,
  output logic [$clog2(Depth)-1:0]    waddr_o,
  output logic [cdq_pkg::WORD_W-1:0]  wdata_o,
  output logic [$clog2(Depth)-1:0]    raddr_f_o,
  output logic [$clog2(Depth)-1:0]    raddr_r_o,
  output logic                        done_o,
  output cdq_pkg::step_status_t       status_o
);
  import cdq_pkg::*;

  localparam int PtrW    = $clog2(Depth);
  localparam int XW      = ((PtrW > CAP_W) ? PtrW : CAP_W) + 1;
  localparam int CapMax  = (Depth < 31) ? Depth : 31;
  localparam int RstCap  = (Depth < CAP_RESET) ? Depth : CAP_RESET;

  logic [CAP_W-1:0] cap_q, eff_cap;
  logic [PtrW-1:0]  front_q, front_d, rear_q, rear_d;
  logic [CAP_W-1:0] count_q, count_d;
  logic             err;
  logic             done_q;
  step_status_t     status_q;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) r = CAP_W'(1);
    else if (c > CAP_W'(CapMax)) r = CAP_W'(CapMax);
    return r;
  endfunction

  function automatic logic [PtrW-1:0] ptr_back(input logic [PtrW-1:0] p,
                                                input logic [CAP_W-1:0] cap);
    logic [PtrW-1:0] r;
    if (p == '0 || XW'(p) >= XW'(cap)) r = PtrW'(cap - CAP_W'(1));
    else r = p - PtrW'(1);
    return r;
  endfunction

  function automatic logic [PtrW-1:0] ptr_fwd(input logic [PtrW-1:0] p,
                                               input logic [CAP_W-1:0] cap);
    logic [PtrW-1:0] r;
    if (XW'(p) + XW'(1) >= XW'(cap)) r = '0;
    else r = p + PtrW'(1);
    return r;
  endfunction

  assign eff_cap = clamp_cap(cap_q);

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    count_d = count_q;
    err     = 1'b0;
    we_o    = 1'b0;
    waddr_o = front_q;
    case (item_i.kind)
      KIND_PUSH_FRONT: begin
        if (count_q >= eff_cap) begin
          err = 1'b1;
        end else begin
          front_d = ptr_back(front_q, eff_cap);
          count_d = count_q + CAP_W'(1);
          we_o    = step_i;
          waddr_o = front_d;
        end
      end
      KIND_PUSH_REAR: begin
        if (count_q >= eff_cap) begin
          err = 1'b1;
        end else begin
          rear_d  = ptr_fwd(rear_q, eff_cap);
          count_d = count_q + CAP_W'(1);
          we_o    = step_i;
          waddr_o = rear_d;
        end
      end
      KIND_POP_FRONT: begin
        if (count_q == '0) begin
          err = 1'b1;
        end else begin
          front_d = ptr_fwd(front_q, eff_cap);
          count_d = count_q - CAP_W'(1);
        end
      end
      KIND_POP_REAR: begin
        if (count_q == '0) begin
          err = 1'b1;
        end else begin
          rear_d  = ptr_back(rear_q, eff_cap);
          count_d = count_q - CAP_W'(1);
        end
      end
      default: begin
        // query, and unused codes behave as query
      end
    endcase
  end

  assign wdata_o   = item_i.value;
  assign raddr_f_o = front_d;
  assign raddr_r_o = rear_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_W'(CAP_RESET);
      front_q <= '0;
      rear_q  <= PtrW'(RstCap - 1);
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= step_i;
      if (cfg_we_i) begin
        // a capacity write also empties the deque
        cap_q   <= cfg_data_i;
        front_q <= '0;
        rear_q  <= PtrW'(clamp_cap(cfg_data_i) - CAP_W'(1));
        count_q <= '0;
      end else if (step_i) begin
        front_q <= front_d;
        rear_q  <= rear_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      status_q.error     <= err;
      status_q.is_empty  <= (count_d == '0);
      status_q.is_full   <= (count_d == eff_cap);
      status_q.occupancy <= count_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

@@ hw/rtl/circular_deque.sv @@
// circular_deque: the result beat is on result_o with done_o
// in the cycle after start is taken; throughput one operation per cycle while busy is low,
// set by the single write port and two read ports of the entry store.
// reset: capacity 16 (clamped to DEPTH), deque empty, stored words undefined.
// busy is high during reset and the first cycle after it; the receiver cannot stall.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  cdq_pkg::deque_in_t         item_i,
  output logic                       done_o,
  output cdq_pkg::deque_out_t        result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cdq_pkg::CAP_W-1:0]  cfg_data_i
);
  import cdq_pkg::*;

  localparam int PtrW = $clog2(DEPTH);

  logic              busy_q, step;
  logic              we;
  logic [PtrW-1:0]   waddr, raddr_f, raddr_r;
  logic [WORD_W-1:0] wdata, rdata_f, rdata_r;
  step_status_t      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign step        = start && !busy_q;
  assign cfg_ready_o = !busy_q;

  cdq_ctrl #(.Depth(DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item_i),
    .cfg_we_i   (cfg_valid_i && !busy_q),
    .cfg_data_i (cfg_data_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_f_o  (raddr_f),
    .raddr_r_o  (raddr_r),
    .done_o     (done_o),
    .status_o   (status)
  );

  cdq_ram #(.Depth(DEPTH)) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_f_i (raddr_f),
    .raddr_r_i (raddr_r),
    .rdata_f_o (rdata_f),
    .rdata_r_o (rdata_r)
  );

  always_comb begin
    result_o.error       = status.error;
    result_o.is_empty    = status.is_empty;
    result_o.is_full     = status.is_full;
    result_o.occupancy   = status.occupancy;
    result_o.front_value = status.is_empty ? '1 : rdata_f;
    result_o.rear_value  = status.is_empty ? '1 : rdata_r;
  end

endmodule

@@ hw/rtl/cdq_checker.sv @@
// cdq_checker: port-level checks on the circular deque, bound to the top level
// sees only the ports of circular_deque; uses cdq_pkg
module cdq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input cdq_pkg::deque_out_t       result_o
);
  import cdq_pkg::*;

  // every accepted beat gives exactly one result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o)
    else $error("accepted beat without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without accepted beat");

  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.is_empty |->
      result_o.occupancy == '0 && result_o.front_value == -32'sd1 &&
      result_o.rear_value == -32'sd1)
    else $error("empty deque reports data");

  // a rejected push leaves it full, a rejected pop leaves it empty
  a_error_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.error |-> result_o.is_empty || result_o.is_full)
    else $error("error while neither full nor empty");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.is_full |-> !result_o.is_empty && result_o.occupancy != '0)
    else $error("full and empty together");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .result_o    (result_o)
);
